>>> sv/adam_pkg.sv
// Shared constants, types and command/status structs for the Adam update block.
package adam_pkg;

  // Moment store geometry
  localparam int PARAM_COUNT = 4096;
  localparam int IDX_W       = $clog2(PARAM_COUNT);

  // Field widths
  localparam int DATA_W  = 32;
  localparam int MOM2_W  = 64;
  localparam int POW_W   = 33;
  localparam int CIDX_W  = 8;

  // Fixed-point constants
  localparam logic [POW_W-1:0] ONE_Q32 = 33'h1_0000_0000;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_BETA_ONE       = 8'd0;
  localparam logic [CIDX_W-1:0] REG_BETA_TWO       = 8'd1;
  localparam logic [CIDX_W-1:0] REG_STEP_SIZE      = 8'd2;
  localparam logic [CIDX_W-1:0] REG_STABILITY_TERM = 8'd3;

  // Configuration reset values
  localparam logic [DATA_W-1:0] BETA_ONE_RST  = 32'd3865470566;
  localparam logic [DATA_W-1:0] BETA_TWO_RST  = 32'd4290672328;
  localparam logic [DATA_W-1:0] STEP_SIZE_RST = 32'd4294967;
  localparam logic [DATA_W-1:0] STAB_RST      = 32'd43;

  // Long divider geometry
  localparam int DVD_W = 96;
  localparam int DSR_W = 41;
  localparam int QUO_W = 64;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] THR_BIAS  = 7'd64;
  localparam logic [CNT_W-1:0] THR_FINAL = 7'd40;

  // Multiplier operand selects
  typedef enum logic [3:0] {
    MS_NONE, MS_P1, MS_P2, MS_MB, MS_GC, MS_GG,
    MS_VL, MS_VH, MS_QL, MS_QH, MS_SL, MS_SH
  } mul_sel_t;

  // Use of the registered product
  typedef enum logic [2:0] {
    U_NONE, U_P1, U_P2, U_GG, U_ACC_LD, U_ACC_ADD, U_ACC_ADD32
  } use_sel_t;

  // Divider job
  typedef enum logic [1:0] {
    DV_M, DV_V, DV_F
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     cap_mem;
    mul_sel_t mul_sel;
    use_sel_t use_sel;
    logic     cap_m;
    logic     wr_mem;
    logic     clr_step;
    div_sel_t div_sel;
    logic     div_start;
    logic     div_load;
    logic     div_skip;
    logic     sqrt_start;
    logic     sqrt_load;
    logic     den_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic p1_one;
    logic p2_one;
    logic den_zero;
    logic div_done;
    logic sqrt_done;
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

>>> sv/adam_optimizer_update_core.sv
// Top level of the Adam parameter update block.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall  | new_pass, element_index, param_value,
//           |           |                    | grad_value
//   out     | output    | out_valid/out_stall| updated_param, saturated
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time; each bias division is skipped while its running power is still
// one, and the bit-serial divider takes most of the time spent on an item.
// After reset a clearing pass over all 4096 entries zeroes the moment stores; no item
// is taken meanwhile, configuration writes are taken always.
// A finished result waits in the output register while the next item is taken.
module adam_optimizer_update_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 new_pass,
  input  logic [11:0]                          element_index,
  input  logic signed [adam_pkg::DATA_W-1:0]   param_value,
  input  logic signed [adam_pkg::DATA_W-1:0]   grad_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [adam_pkg::DATA_W-1:0]   updated_param,
  output logic                                 saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adam_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [adam_pkg::DATA_W-1:0]          cfg_data
);

  adam_pkg::cmd_t  cmd;
  adam_pkg::stat_t stat;

  // Take configuration writes in any cycle
  assign cfg_ready = 1'b1;

  adam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  adam_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .new_pass      (new_pass),
    .element_index (element_index),
    .param_value   (param_value),
    .grad_value    (grad_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .updated_param (updated_param),
    .saturated     (saturated)
  );

endmodule

>>> sv/adam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module adam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/adam_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, with overflow flag.
module adam_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [adam_pkg::DVD_W-1:0]     dividend,
  input  logic [adam_pkg::DSR_W-1:0]     divisor,
  input  logic [adam_pkg::CNT_W-1:0]     thresh,
  output logic                           done,
  output logic [adam_pkg::QUO_W-1:0]     quo,
  output logic                           big
);

  logic                          busy;
  logic [adam_pkg::CNT_W-1:0]    cnt;
  logic [adam_pkg::CNT_W-1:0]    thr;
  logic [adam_pkg::DVD_W-1:0]    dvd;
  logic [adam_pkg::DSR_W-1:0]    dsr;
  logic [adam_pkg::DSR_W-1:0]    rem;
  logic [adam_pkg::DSR_W:0]      rem_sh;
  logic [adam_pkg::DSR_W:0]      diff;
  logic                          ge;
  logic                          hi_bit;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem, dvd[adam_pkg::DVD_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = rem_sh >= {1'b0, dsr};
    hi_bit = cnt >= thr;
  end

  // Control: busy and done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: one bit per cycle from the top
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      thr <= thresh;
      rem <= '0;
      quo <= '0;
      big <= 1'b0;
      cnt <= adam_pkg::CNT_W'(adam_pkg::DVD_W - 1);
    end else if (busy) begin
      dvd <= {dvd[adam_pkg::DVD_W-2:0], 1'b0};
      rem <= ge ? diff[adam_pkg::DSR_W-1:0] : rem_sh[adam_pkg::DSR_W-1:0];
      quo <= {quo[adam_pkg::QUO_W-2:0], ge && !hi_bit};
      big <= big | (ge && hi_bit);
      cnt <= cnt - 1'b1;
    end
  end

endmodule

>>> sv/adam_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module adam_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [adam_pkg::MOM2_W-1:0]   x,
  output logic                          done,
  output logic [adam_pkg::DATA_W-1:0]   root
);

  logic                        busy;
  logic [adam_pkg::MOM2_W-1:0] rad;
  logic [adam_pkg::MOM2_W-1:0] res;
  logic [adam_pkg::MOM2_W-1:0] bitv;
  logic [adam_pkg::MOM2_W:0]   sum;
  logic                        ge;

  // Trial value
  always_comb begin
    sum = {1'b0, res} + {1'b0, bitv};
    ge  = {1'b0, rad} >= sum;
  end

  assign root = res[adam_pkg::DATA_W-1:0];

  // Control: busy and done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && bitv[0];
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: advance one bit pair
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= x;
      res  <= '0;
      bitv <= {2'b01, {(adam_pkg::MOM2_W-2){1'b0}}};
    end else if (busy) begin
      if (ge) begin
        rad <= rad - sum[adam_pkg::MOM2_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

>>> sv/adam_dp.sv
// Adam datapath: config registers, moment stores, shared multiplier, divider, root.
module adam_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  adam_pkg::cmd_t                       cmd,
  output adam_pkg::stat_t                      stat,
  input  logic                                 cfg_we,
  input  logic [adam_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [adam_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                 new_pass,
  input  logic [11:0]                          element_index,
  input  logic signed [adam_pkg::DATA_W-1:0]   param_value,
  input  logic signed [adam_pkg::DATA_W-1:0]   grad_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [adam_pkg::DATA_W-1:0]   updated_param,
  output logic                                 saturated
);

  // Configuration
  logic [adam_pkg::DATA_W-1:0] beta_one, beta_two, step_size, stability_term;
  // Running state
  logic [adam_pkg::POW_W-1:0]  p1, p2;
  logic [adam_pkg::DATA_W-1:0] step_count;
  // Item registers
  logic                               pass_r;
  logic [adam_pkg::IDX_W-1:0]         idx_r;
  logic signed [adam_pkg::DATA_W-1:0] param_r, grad_r, m_old, m_new;
  logic [adam_pkg::MOM2_W-1:0]        v_old, v_new, gg, mhat, vhat;
  logic signed [67:0]                 prod;
  logic signed [97:0]                 acc;
  logic signed [97:0]                 prod_ext;
  logic [adam_pkg::DATA_W-1:0]        root;
  logic [adam_pkg::DSR_W-1:0]         den;
  logic                               mag_big;
  logic [39:0]                        mag_q;
  logic [adam_pkg::IDX_W-1:0]         clr_cnt;
  // Combinational helpers
  logic [adam_pkg::POW_W-1:0]   c1, c2, d1, d2;
  logic [adam_pkg::DATA_W-1:0]  gabs, mabs;
  logic signed [33:0]           mul_a, mul_b;
  logic                         mem_we;
  logic [adam_pkg::IDX_W-1:0]   mem_waddr;
  logic [adam_pkg::DATA_W-1:0]  m_wdata, m_rdata;
  logic [adam_pkg::MOM2_W-1:0]  v_wdata, v_rdata;
  logic [adam_pkg::DVD_W-1:0]   div_dvd;
  logic [adam_pkg::DSR_W-1:0]   div_dsr;
  logic [adam_pkg::CNT_W-1:0]   div_thr;
  logic                         div_done, div_big;
  logic [adam_pkg::QUO_W-1:0]   div_q;
  logic                         sqrt_done;
  logic [adam_pkg::DATA_W-1:0]  sqrt_root;
  logic [41:0]                  mag, p_ext, res;
  logic                         sat_hi, sat_lo;

  assign c1   = adam_pkg::ONE_Q32 - {1'b0, beta_one};
  assign c2   = adam_pkg::ONE_Q32 - {1'b0, beta_two};
  assign d1   = adam_pkg::ONE_Q32 - p1;
  assign d2   = adam_pkg::ONE_Q32 - p2;
  assign gabs = grad_r[adam_pkg::DATA_W-1] ? (~grad_r + 1'b1) : grad_r;
  assign mabs = m_new[adam_pkg::DATA_W-1] ? (~m_new + 1'b1) : m_new;
  assign prod_ext = {{30{prod[67]}}, prod};

  // Moment stores
  assign mem_we    = cmd.wr_mem | cmd.clr_step;
  assign mem_waddr = cmd.clr_step ? clr_cnt : idx_r;
  assign m_wdata   = cmd.clr_step ? '0 : m_new;
  assign v_wdata   = cmd.clr_step ? '0 : acc[95:32];

  adam_ram #(.WIDTH(adam_pkg::DATA_W), .DEPTH(adam_pkg::PARAM_COUNT)) u_m_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (m_wdata),
    .raddr (element_index[adam_pkg::IDX_W-1:0]),
    .rdata (m_rdata)
  );

  adam_ram #(.WIDTH(adam_pkg::MOM2_W), .DEPTH(adam_pkg::PARAM_COUNT)) u_v_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (v_wdata),
    .raddr (element_index[adam_pkg::IDX_W-1:0]),
    .rdata (v_rdata)
  );

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      adam_pkg::MS_P1: begin
        mul_a = $signed({1'b0, p1});
        mul_b = $signed({2'b00, beta_one});
      end
      adam_pkg::MS_P2: begin
        mul_a = $signed({1'b0, p2});
        mul_b = $signed({2'b00, beta_two});
      end
      adam_pkg::MS_MB: begin
        mul_a = 34'(m_old);
        mul_b = $signed({2'b00, beta_one});
      end
      adam_pkg::MS_GC: begin
        mul_a = 34'(grad_r);
        mul_b = $signed({1'b0, c1});
      end
      adam_pkg::MS_GG: begin
        mul_a = $signed({2'b00, gabs});
        mul_b = $signed({2'b00, gabs});
      end
      adam_pkg::MS_VL: begin
        mul_a = $signed({2'b00, v_old[31:0]});
        mul_b = $signed({2'b00, beta_two});
      end
      adam_pkg::MS_VH: begin
        mul_a = $signed({2'b00, v_old[63:32]});
        mul_b = $signed({2'b00, beta_two});
      end
      adam_pkg::MS_QL: begin
        mul_a = $signed({2'b00, gg[31:0]});
        mul_b = $signed({1'b0, c2});
      end
      adam_pkg::MS_QH: begin
        mul_a = $signed({2'b00, gg[63:32]});
        mul_b = $signed({1'b0, c2});
      end
      adam_pkg::MS_SL: begin
        mul_a = $signed({2'b00, mhat[31:0]});
        mul_b = $signed({2'b00, step_size});
      end
      adam_pkg::MS_SH: begin
        mul_a = $signed({2'b00, mhat[63:32]});
        mul_b = $signed({2'b00, step_size});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider operand select
  always_comb begin
    case (cmd.div_sel)
      adam_pkg::DV_M: begin
        div_dvd = {32'b0, mabs, 32'b0};
        div_dsr = {8'b0, d1};
        div_thr = adam_pkg::THR_BIAS;
      end
      adam_pkg::DV_V: begin
        div_dvd = {v_new, 32'b0};
        div_dsr = {8'b0, d2};
        div_thr = adam_pkg::THR_BIAS;
      end
      default: begin
        div_dvd = acc[95:0];
        div_dsr = den;
        div_thr = adam_pkg::THR_FINAL;
      end
    endcase
  end

  adam_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .thresh   (div_thr),
    .done     (div_done),
    .quo      (div_q),
    .big      (div_big)
  );

  adam_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .x     (vhat),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Final sum and saturation
  always_comb begin
    mag    = mag_big ? (42'd1 << 40) : {2'b00, mag_q};
    p_ext  = 42'(param_r);
    res    = m_new[adam_pkg::DATA_W-1] ? (p_ext + mag) : (p_ext - mag);
    sat_hi = !res[41] && (|res[40:31]);
    sat_lo = res[41] && !(&res[40:31]);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beta_one       <= adam_pkg::BETA_ONE_RST;
      beta_two       <= adam_pkg::BETA_TWO_RST;
      step_size      <= adam_pkg::STEP_SIZE_RST;
      stability_term <= adam_pkg::STAB_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        adam_pkg::REG_BETA_ONE:       beta_one       <= cfg_data;
        adam_pkg::REG_BETA_TWO:       beta_two       <= cfg_data;
        adam_pkg::REG_STEP_SIZE:      step_size      <= cfg_data;
        adam_pkg::REG_STABILITY_TERM: stability_term <= cfg_data;
        default: ;
      endcase
    end
  end

  // Running powers, step count, clear counter, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      p1         <= adam_pkg::ONE_Q32;
      p2         <= adam_pkg::ONE_Q32;
      step_count <= '0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.use_sel == adam_pkg::U_P1 && pass_r) begin
        p1         <= prod[64:32];
        step_count <= step_count + 1'b1;
      end
      if (cmd.use_sel == adam_pkg::U_P2 && pass_r) begin
        p2 <= prod[64:32];
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item payload, product, accumulator, quotient, root and output registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pass_r  <= new_pass;
      idx_r   <= element_index[adam_pkg::IDX_W-1:0];
      param_r <= param_value;
      grad_r  <= grad_value;
    end
    if (cmd.cap_mem) begin
      m_old <= m_rdata;
      v_old <= v_rdata;
    end
    prod <= mul_a * mul_b;
    case (cmd.use_sel)
      adam_pkg::U_GG:        gg  <= prod[63:0];
      adam_pkg::U_ACC_LD:    acc <= prod_ext;
      adam_pkg::U_ACC_ADD:   acc <= acc + prod_ext;
      adam_pkg::U_ACC_ADD32: acc <= acc + {prod_ext[65:0], 32'b0};
      default: ;
    endcase
    if (cmd.cap_m) begin
      m_new <= acc[63:32];
    end
    if (cmd.wr_mem) begin
      v_new <= acc[95:32];
    end
    // Load bias-corrected or final quotient
    if (cmd.div_load || cmd.div_skip) begin
      case (cmd.div_sel)
        adam_pkg::DV_M: begin
          mhat <= cmd.div_skip ? {32'b0, mabs} : (div_big ? '1 : div_q);
        end
        adam_pkg::DV_V: begin
          vhat <= cmd.div_skip ? v_new : (div_big ? '1 : div_q);
        end
        default: begin
          mag_big <= cmd.div_skip ? (|acc[95:0]) : div_big;
          mag_q   <= cmd.div_skip ? '0 : div_q[39:0];
        end
      endcase
    end
    if (cmd.sqrt_load) begin
      root <= sqrt_root;
    end
    if (cmd.den_load) begin
      den <= {1'b0, root, 8'b0} + {9'b0, stability_term};
    end
    if (cmd.out_load) begin
      updated_param <= sat_hi ? 32'sh7fff_ffff : (sat_lo ? 32'sh8000_0000 : res[31:0]);
      saturated     <= sat_hi | sat_lo;
    end
  end

  // Status to the controller
  always_comb begin
    stat.p1_one     = p1 == adam_pkg::ONE_Q32;
    stat.p2_one     = p2 == adam_pkg::ONE_Q32;
    stat.den_zero   = den == '0;
    stat.div_done   = div_done;
    stat.sqrt_done  = sqrt_done;
    stat.clear_last = clr_cnt == adam_pkg::IDX_W'(adam_pkg::PARAM_COUNT - 1);
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

>>> sv/adam_ctrl.sv
// Adam controller: sequences clear pass, multiplies, divisions and root per item.
module adam_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  adam_pkg::stat_t stat,
  output adam_pkg::cmd_t  cmd
);

  typedef enum logic [24:0] {
    ST_CLEAR = 25'h0000001,
    ST_IDLE  = 25'h0000002,
    ST_POW1  = 25'h0000004,
    ST_POW2  = 25'h0000008,
    ST_MB    = 25'h0000010,
    ST_GC    = 25'h0000020,
    ST_GG    = 25'h0000040,
    ST_VL    = 25'h0000080,
    ST_VH    = 25'h0000100,
    ST_QL    = 25'h0000200,
    ST_QH    = 25'h0000400,
    ST_VSUM  = 25'h0000800,
    ST_WB    = 25'h0001000,
    ST_MHAT  = 25'h0002000,
    ST_DIVM  = 25'h0004000,
    ST_VHAT  = 25'h0008000,
    ST_DIVV  = 25'h0010000,
    ST_ROOT  = 25'h0020000,
    ST_SQW   = 25'h0040000,
    ST_SL    = 25'h0080000,
    ST_SH    = 25'h0100000,
    ST_PSUM  = 25'h0200000,
    ST_FDIV  = 25'h0400000,
    ST_DIVF  = 25'h0800000,
    ST_FIN   = 25'h1000000
  } state_t;

  state_t state, state_next;

  assign in_stall = state != ST_IDLE;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the update sequence
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_POW1;
        end
      end
      ST_POW1: begin
        cmd.cap_mem = 1'b1;
        cmd.mul_sel = adam_pkg::MS_P1;
        state_next  = ST_POW2;
      end
      ST_POW2: begin
        cmd.use_sel = adam_pkg::U_P1;
        cmd.mul_sel = adam_pkg::MS_P2;
        state_next  = ST_MB;
      end
      ST_MB: begin
        cmd.use_sel = adam_pkg::U_P2;
        cmd.mul_sel = adam_pkg::MS_MB;
        state_next  = ST_GC;
      end
      ST_GC: begin
        cmd.use_sel = adam_pkg::U_ACC_LD;
        cmd.mul_sel = adam_pkg::MS_GC;
        state_next  = ST_GG;
      end
      ST_GG: begin
        cmd.use_sel = adam_pkg::U_ACC_ADD;
        cmd.mul_sel = adam_pkg::MS_GG;
        state_next  = ST_VL;
      end
      ST_VL: begin
        cmd.use_sel = adam_pkg::U_GG;
        cmd.cap_m   = 1'b1;
        cmd.mul_sel = adam_pkg::MS_VL;
        state_next  = ST_VH;
      end
      ST_VH: begin
        cmd.use_sel = adam_pkg::U_ACC_LD;
        cmd.mul_sel = adam_pkg::MS_VH;
        state_next  = ST_QL;
      end
      ST_QL: begin
        cmd.use_sel = adam_pkg::U_ACC_ADD32;
        cmd.mul_sel = adam_pkg::MS_QL;
        state_next  = ST_QH;
      end
      ST_QH: begin
        cmd.use_sel = adam_pkg::U_ACC_ADD;
        cmd.mul_sel = adam_pkg::MS_QH;
        state_next  = ST_VSUM;
      end
      ST_VSUM: begin
        cmd.use_sel = adam_pkg::U_ACC_ADD32;
        state_next  = ST_WB;
      end
      ST_WB: begin
        cmd.wr_mem = 1'b1;
        state_next = ST_MHAT;
      end
      ST_MHAT: begin
        cmd.div_sel = adam_pkg::DV_M;
        if (stat.p1_one) begin
          cmd.div_skip = 1'b1;
          state_next   = ST_VHAT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVM;
        end
      end
      ST_DIVM: begin
        cmd.div_sel = adam_pkg::DV_M;
        if (stat.div_done) begin
          cmd.div_load = 1'b1;
          state_next   = ST_VHAT;
        end
      end
      ST_VHAT: begin
        cmd.div_sel = adam_pkg::DV_V;
        if (stat.p2_one) begin
          cmd.div_skip = 1'b1;
          state_next   = ST_ROOT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVV;
        end
      end
      ST_DIVV: begin
        cmd.div_sel = adam_pkg::DV_V;
        if (stat.div_done) begin
          cmd.div_load = 1'b1;
          state_next   = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.sqrt_start = 1'b1;
        state_next     = ST_SQW;
      end
      ST_SQW: begin
        if (stat.sqrt_done) begin
          cmd.sqrt_load = 1'b1;
          state_next    = ST_SL;
        end
      end
      ST_SL: begin
        cmd.mul_sel = adam_pkg::MS_SL;
        state_next  = ST_SH;
      end
      ST_SH: begin
        cmd.use_sel = adam_pkg::U_ACC_LD;
        cmd.mul_sel = adam_pkg::MS_SH;
        state_next  = ST_PSUM;
      end
      ST_PSUM: begin
        cmd.use_sel  = adam_pkg::U_ACC_ADD32;
        cmd.den_load = 1'b1;
        state_next   = ST_FDIV;
      end
      ST_FDIV: begin
        cmd.div_sel = adam_pkg::DV_F;
        if (stat.den_zero) begin
          cmd.div_skip = 1'b1;
          state_next   = ST_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVF;
        end
      end
      ST_DIVF: begin
        cmd.div_sel = adam_pkg::DV_F;
        if (stat.div_done) begin
          cmd.div_load = 1'b1;
          state_next   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/adam_chk.sv
// Port-level checker for the Adam update block, bound to the top level.
module adam_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [adam_pkg::DATA_W-1:0]  updated_param,
  input logic                                saturated
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(updated_param) && $stable(saturated))
    else $error("result changed while stalled");

  // Clearing pass blocks input after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open during clearing pass");

  // Accepted transaction keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // Saturation flag matches a clipped value
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      updated_param == 32'sh7fff_ffff || updated_param == 32'sh8000_0000)
    else $error("saturated flag on unclipped value");

endmodule

bind adam_optimizer_update_core adam_chk u_chk (.*);
